/* rtl/ssdg_pkg.sv */
// ----------------------------------------------------------------------------
// ssdg_pkg
// shared types and codes of the step/direction generator with homing
// ----------------------------------------------------------------------------
package ssdg_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_HOME   = 2'd2;

  // register byte addresses
  localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
  localparam logic [2:0] ADDR_BACKOFF     = 3'd4;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd80;
  localparam logic [7:0]  BACKOFF_RST     = 8'd15;

  // controller mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_BACKOFF = 4'b0010,
    MODE_SEEK    = 4'b0100,
    MODE_RUN     = 4'b1000
  } mode_t;

endpackage

/* rtl/stepper_step_dir_generator_homing.sv */
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_homing
// tick-driven step/direction generator with position tracking and homing
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one word per timer tick or command. in_tuser holds the operation
//           (tick, set target and interval, start homing); in_tdata holds
//           the target, the step interval and the home sensor level.
//   out_* : one result word for every input word: step and direction pin
//           levels, position, target minus position, last captured period
//           and the ready flag (homing done).
//   cfg_* : apb-style register port, homing half period at 0x0 and backoff
//           pulse count at 0x4; write only while no word is in flight.
// stages: a word is registered in the input register and its result in the
//   output register.
// throughput: one word per cycle while out_tready is high; the state update
//   is one pass (signed 32-bit compares and a position step) between registers.
// reset: the block comes up unhomed; ticks do nothing until a homing run
//   is started. registers return to 80 and 15.
// stall: while out_tready is low the result is held and one more word can
//   still wait in the input register; after that in_tready drops.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator_homing
  import ssdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_pulses[31:0], step_interval[47:32], home_switch[48], zero pad
  input  logic [55:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // step_level[0], direction_level[1], current_position[33:2],
  // position_error[66:34], last_period[83:67], ready_res[84], zero pad
  output logic [87:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [15:0] half_period_r;
  logic [7:0]  backoff_r;

  // input register
  logic        in_vld_r;
  logic [1:0]  op_r;
  logic [31:0] in_tgt_r;
  logic [15:0] in_ivl_r;
  logic        in_sensor_r;

  // controller state
  mode_t       mode_r, mode_nxt;
  logic [16:0] tick_r, tick_nxt;
  logic [15:0] ivl_r, ivl_nxt;
  logic        step_r, step_nxt;
  logic        dir_r, dir_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [16:0] period_r, period_nxt;
  logic [7:0]  steps_left_r, steps_left_nxt;
  logic [15:0] half_cnt_r, half_cnt_nxt;

  // output register
  logic        out_vld_r;
  logic [87:0] out_data_r, out_data_nxt;

  logic        adv;
  logic        in_fire;
  logic        upd;
  logic        cfg_wr;
  logic        do_seek;
  logic [15:0] half_inc;
  logic [7:0]  steps_dec;
  logic [32:0] err;

  // pipeline moves when the output slot is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign upd       = adv && in_vld_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {24'd0, backoff_r} : {16'd0, half_period_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      backoff_r     <= BACKOFF_RST;
    end else if (cfg_wr) begin
      // low address bits are ignored, bit 2 picks the register
      if (cfg_paddr[2] == ADDR_BACKOFF[2]) begin
        backoff_r <= cfg_pwdata[7:0];
      end else begin
        half_period_r <= cfg_pwdata[15:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_tuser;
      in_tgt_r    <= in_tdata[31:0];
      in_ivl_r    <= in_tdata[47:32];
      in_sensor_r <= in_tdata[48];
    end
  end

  // one pass of the controller for the word in the input register
  always_comb begin
    mode_nxt       = mode_r;
    tick_nxt       = tick_r;
    ivl_nxt        = ivl_r;
    step_nxt       = step_r;
    dir_nxt        = dir_r;
    pos_nxt        = pos_r;
    tgt_nxt        = tgt_r;
    period_nxt     = period_r;
    steps_left_nxt = steps_left_r;
    half_cnt_nxt   = half_cnt_r;
    do_seek        = 1'b0;
    half_inc       = half_cnt_r + 16'd1;
    steps_dec      = steps_left_r - 8'd1;

    case (op_r)
      OP_TICK: begin
        unique case (mode_r)
          MODE_BACKOFF, MODE_SEEK: begin
            if (half_inc < half_period_r) begin
              half_cnt_nxt = half_inc;
            end else begin
              half_cnt_nxt = 16'd0;
              if (step_r) begin
                // end of the high half
                step_nxt = 1'b0;
              end else if (mode_r == MODE_BACKOFF) begin
                steps_left_nxt = steps_dec;
                if (steps_dec == 8'd0) begin
                  dir_nxt  = 1'b0;
                  mode_nxt = MODE_SEEK;
                  do_seek  = 1'b1;
                end else begin
                  step_nxt = 1'b1;
                end
              end else begin
                do_seek = 1'b1;
              end
            end
          end
          MODE_RUN: begin
            if (tick_r > {1'b0, ivl_r}) begin
              if ($signed(tgt_r) > $signed(pos_r)) begin
                dir_nxt  = 1'b1;
                step_nxt = !step_r;
                if (step_r) begin
                  pos_nxt = pos_r + 32'd1;
                end
              end else if ($signed(tgt_r) < $signed(pos_r)) begin
                dir_nxt  = 1'b0;
                step_nxt = !step_r;
                if (step_r) begin
                  pos_nxt = pos_r - 32'd1;
                end
              end
              period_nxt = tick_r;
              tick_nxt   = 17'd0;
            end else begin
              tick_nxt = tick_r + 17'd1;
            end
          end
          MODE_IDLE: begin
          end
        endcase
      end
      OP_SET: begin
        tgt_nxt = in_tgt_r;
        ivl_nxt = in_ivl_r;
      end
      OP_HOME: begin
        tgt_nxt        = 32'd0;
        dir_nxt        = 1'b1;
        half_cnt_nxt   = 16'd0;
        steps_left_nxt = backoff_r;
        if (backoff_r != 8'd0) begin
          mode_nxt = MODE_BACKOFF;
          step_nxt = 1'b1;
        end else begin
          mode_nxt = MODE_SEEK;
          dir_nxt  = 1'b0;
          do_seek  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // start of a seek pulse: pulse again while not home, else finish homing
    if (do_seek) begin
      half_cnt_nxt = 16'd0;
      if (in_sensor_r) begin
        step_nxt = 1'b1;
      end else begin
        step_nxt = 1'b0;
        pos_nxt  = 32'd0;
        tgt_nxt  = 32'd0;
        mode_nxt = MODE_RUN;
      end
    end

    err = {tgt_nxt[31], tgt_nxt} - {pos_nxt[31], pos_nxt};
    out_data_nxt = {3'd0, (mode_nxt == MODE_RUN), period_nxt, err, pos_nxt,
                    dir_nxt, step_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      tick_r       <= 17'd0;
      ivl_r        <= 16'd0;
      step_r       <= 1'b0;
      dir_r        <= 1'b0;
      pos_r        <= 32'd0;
      tgt_r        <= 32'd0;
      period_r     <= 17'd0;
      steps_left_r <= 8'd0;
      half_cnt_r   <= 16'd0;
    end else if (upd) begin
      mode_r       <= mode_nxt;
      tick_r       <= tick_nxt;
      ivl_r        <= ivl_nxt;
      step_r       <= step_nxt;
      dir_r        <= dir_nxt;
      pos_r        <= pos_nxt;
      tgt_r        <= tgt_nxt;
      period_r     <= period_nxt;
      steps_left_r <= steps_left_nxt;
      half_cnt_r   <= half_cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a word taken from the input register shows up as a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_vld_r)
    else $error("result missing after update");

  // before the first homing run nothing moves
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (pos_r == 32'd0) && !step_r && !dir_r)
    else $error("pins or position moved before homing");

  // entering run mode always starts from a cleared position and target
  a_home_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_RUN) && ($past(mode_r) != MODE_RUN)
    |-> (pos_r == 32'd0) && (tgt_r == 32'd0) && !step_r)
    else $error("homing finished without clearing position");

  // a homing request with backoff pulses enters backoff with step high
  a_home_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (op_r == OP_HOME) && (backoff_r != 8'd0)
    |=> (mode_r == MODE_BACKOFF) && step_r && dir_r)
    else $error("homing request did not start backoff");
`endif

endmodule
